FILE: rtl/hvn_pkg.sv
// Package: shared types and constants of the heightmap vertex/normal block.
package hvn_pkg;

  // heightmap samples per side held in the store
  localparam int MAX_GRID = 256;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [1:0] REG_GRID_SIZE    = 2'd0;
  localparam logic [1:0] REG_HEIGHT_SCALE = 2'd1;
  localparam logic [1:0] REG_GAIN_X       = 2'd2;
  localparam logic [1:0] REG_GAIN_Z       = 2'd3;

  typedef struct packed {
    logic        func;
    logic [7:0]  coord_x;
    logic [7:0]  coord_z;
    logic [15:0] height_value;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] vertex_y;
    logic signed [15:0] normal_x;
    logic [14:0]        normal_y;
    logic signed [15:0] normal_z;
  } out_item_t;

endpackage

FILE: rtl/hvn_ram.sv
// Generic single-port RAM with registered read.
module hvn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/hvn_divider.sv
// Radix-2 restoring divider with round-half-up, one quotient bit per cycle.
module hvn_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [37:0] dividend,
  input  logic [24:0] divisor,
  output logic        done,
  output logic [15:0] quotient
);

  logic [38:0] num_r, num_nxt;
  logic [25:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [24:0] div_r;
  logic        busy_r, busy_nxt;
  logic [25:0] trial;

  // numerator = dividend + divisor/2, quotient bits shift in at num_r LSB
  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r[24:0], num_r[38]};
    done     = 1'b0;
    if (start) begin
      num_nxt  = {1'b0, dividend} + {15'd0, divisor[24:1]};
      rem_nxt  = '0;
      cnt_nxt  = 6'd39;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = trial - {1'b0, div_r};
        num_nxt = {num_r[37:0], 1'b1};
      end else begin
        rem_nxt = trial;
        num_nxt = {num_r[37:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done     = 1'b1;
      end
    end
  end

  assign quotient = num_nxt[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      div_r <= divisor;
    end
  end

endmodule

FILE: rtl/heightmap_vertex_normal.sv
// Top level: heightmap store with per-vertex height and unit normal queries.
// A write transaction stores one sample in the single-port height memory in
// the cycle it is accepted, so writes can follow back to back. A query reads
// five samples from that port (centre, right, left, up, down; one per cycle),
// forms the scaled height and the two slopes with one shared 16x16 multiplier,
// squares both slopes, then runs a 25-step integer square root and three
// restoring divisions on one shared divider. The next transaction can be
// accepted in the same cycle that the result becomes valid. A finished result
// waits in the output register while the next transaction is accepted; a
// query that completes while that register is still full holds until it is
// taken. Samples never written read back undefined, so queries must only
// touch written samples; no clearing pass is run after reset.
module heightmap_vertex_normal
  import hvn_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CW = $clog2(MAX_GRID);
  localparam int AW = 2 * CW;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_RD   = 10'b0000000010,
    S_MUL  = 10'b0000000100,
    S_SQ   = 10'b0000001000,
    S_SQRT = 10'b0000010000,
    S_DIVX = 10'b0000100000,
    S_DIVY = 10'b0001000000,
    S_DIVZ = 10'b0010000000,
    S_OUT  = 10'b0100000000,
    S_WAIT = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [8:0]  grid_r;
  logic [15:0] hscale_r, gain_x_r, gain_z_r;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r   <= 9'd256;
      hscale_r <= 16'd256;
      gain_x_r <= 16'd128;
      gain_z_r <= 16'd128;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GRID_SIZE:    grid_r   <= cfg_data[8:0];
        REG_HEIGHT_SCALE: hscale_r <= cfg_data;
        REG_GAIN_X:       gain_x_r <= cfg_data;
        REG_GAIN_Z:       gain_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective grid bound n-1
  logic [CW:0] nmax;
  always_comb begin
    if (grid_r < 9'd2) begin
      nmax = (CW+1)'(1);
    end else if ({23'd0, grid_r} > MAX_GRID) begin
      nmax = (CW+1)'(MAX_GRID - 1);
    end else begin
      nmax = (CW+1)'(grid_r - 9'd1);
    end
  end

  logic [CW:0] cx_r, cz_r;
  logic [2:0]  rd_idx_r;
  logic [15:0] h_r [5];
  logic        rd_pend_r;

  // neighbour coordinate clamp, applied to the raw query coordinates
  logic signed [CW+2:0] ax, az;
  logic [CW-1:0] fx, fz;
  always_comb begin
    ax = signed'({2'b0, cx_r});
    az = signed'({2'b0, cz_r});
    case (rd_idx_r)
      3'd1: ax = ax + (CW+3)'(1);
      3'd2: ax = ax - (CW+3)'(1);
      3'd3: az = az + (CW+3)'(1);
      3'd4: az = az - (CW+3)'(1);
      default: ;
    endcase
    if (ax < 0) fx = '0;
    else if (ax > signed'({2'b0, nmax})) fx = nmax[CW-1:0];
    else fx = ax[CW-1:0];
    if (az < 0) fz = '0;
    else if (az > signed'({2'b0, nmax})) fz = nmax[CW-1:0];
    else fz = az[CW-1:0];
  end

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [15:0]   ram_rdata;
  logic          in_fire, wr_ok;

  assign in_fire = in_valid && in_ready;
  assign wr_ok = ({24'd0, in_data.coord_x} < MAX_GRID) && ({24'd0, in_data.coord_z} < MAX_GRID);
  assign ram_we = in_fire && (in_data.func == FUNC_WRITE) && wr_ok;
  assign ram_addr = (state_r == S_IDLE) ?
                    {in_data.coord_z[CW-1:0], in_data.coord_x[CW-1:0]} : {fz, fx};

  hvn_ram #(.WIDTH(16), .DEPTH(MAX_GRID * MAX_GRID)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(in_data.height_value),
    .rdata(ram_rdata)
  );

  // arithmetic registers
  logic [31:0] prod_r;
  logic [1:0]  mstep_r;
  logic signed [31:0] ycalc_r;
  logic [15:0] vy_r;
  logic [23:0] mx_r, mz_r;
  logic        sx_r, sz_r;
  logic [47:0] sqx, sqz;
  logic [48:0] l2;
  logic [24:0] norm_r;
  logic [15:0] qx_r, qy_r, qz_r;
  logic [5:0]  sq_cnt_r;
  logic [49:0] sq_v_r;
  logic [24:0] sq_res_r;
  logic [16:0] dx, dz;
  logic [15:0] adx, adz;
  logic [15:0] mul_a, mul_b;

  assign dx = {1'b0, h_r[1]} - {1'b0, h_r[2]};
  assign dz = {1'b0, h_r[3]} - {1'b0, h_r[4]};
  assign adx = dx[16] ? 16'(-dx) : dx[15:0];
  assign adz = dz[16] ? 16'(-dz) : dz[15:0];

  // squared length of the unscaled normal
  assign sqx = mx_r * mx_r;
  assign sqz = mz_r * mz_r;
  assign l2  = {1'b0, sqx} + {1'b0, sqz} + 49'h1_0000_0000;

  // shared multiplier operand select
  always_comb begin
    case (mstep_r)
      2'd0: begin mul_a = h_r[0]; mul_b = hscale_r; end
      2'd1: begin mul_a = adx;    mul_b = gain_x_r; end
      default: begin mul_a = adz; mul_b = gain_z_r; end
    endcase
  end

  // square root of L2: restoring, two bits per step on a 50-bit radicand
  logic [24:0] sq_res_nxt;
  logic [49:0] sq_v_nxt;
  logic [27:0] sq_trial;
  logic [27:0] sq_rem_r, sq_rem_nxt;
  always_comb begin
    sq_trial   = {sq_rem_r[25:0], sq_v_r[49:48]};
    sq_res_nxt = sq_res_r;
    sq_rem_nxt = sq_rem_r;
    if (sq_trial >= {1'b0, sq_res_r, 2'b01}) begin
      sq_rem_nxt = sq_trial - {1'b0, sq_res_r, 2'b01};
      sq_res_nxt = {sq_res_r[23:0], 1'b1};
    end else begin
      sq_rem_nxt = sq_trial;
      sq_res_nxt = {sq_res_r[23:0], 1'b0};
    end
    sq_v_nxt = {sq_v_r[47:0], 2'b00};
  end

  // divider
  logic        div_start, div_done;
  logic [37:0] div_num;
  logic [15:0] div_q;
  logic        div_go_r;

  always_comb begin
    case (state_r)
      S_DIVX:  div_num = {mx_r, 14'd0};
      S_DIVZ:  div_num = {mz_r, 14'd0};
      default: div_num = 38'h00_4000_0000;
    endcase
  end
  assign div_start = div_go_r;

  hvn_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_num),
    .divisor(norm_r), .done(div_done), .quotient(div_q)
  );

  // result register loads once the previous result has been taken
  logic out_load;
  assign out_load = (state_r == S_OUT) && (!out_valid || out_ready);

  assign in_ready = (state_r == S_IDLE);

  // control sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_fire && in_data.func == FUNC_QUERY) state_nxt = S_RD;
      S_RD:   if (rd_pend_r && rd_idx_r == 3'd5) state_nxt = S_MUL;
      S_MUL:  if (mstep_r == 2'd3) state_nxt = S_SQ;
      S_SQ:   state_nxt = S_SQRT;
      S_SQRT: if (sq_cnt_r == 6'd1) state_nxt = S_DIVX;
      S_DIVX: if (div_done) state_nxt = S_DIVY;
      S_DIVY: if (div_done) state_nxt = S_DIVZ;
      S_DIVZ: if (div_done) state_nxt = S_OUT;
      S_OUT:  if (out_load) state_nxt = S_IDLE;
      S_WAIT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  logic signed [32:0] ysum;
  assign ysum = signed'({1'b0, prod_r}) - signed'({2'b0, hscale_r, 15'd0})
              + 33'sd32768;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
      div_go_r  <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      div_go_r <= (state_r == S_SQRT && sq_cnt_r == 6'd1)
               || (state_r == S_DIVX && div_done) || (state_r == S_DIVY && div_done);
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (state_r == S_IDLE) rd_pend_r <= 1'b0;
      else if (state_r == S_RD) rd_pend_r <= 1'b1;
    end
    // query launch, coordinates kept raw and clamped per read
    if (state_r == S_IDLE) begin
      cx_r     <= (CW+1)'(in_data.coord_x);
      cz_r     <= (CW+1)'(in_data.coord_z);
      rd_idx_r <= 3'd0;
      mstep_r  <= 2'd0;
    end
    // sample fetch, one read per cycle
    if (state_r == S_RD) begin
      if (rd_idx_r != 3'd5) rd_idx_r <= rd_idx_r + 3'd1;
      if (rd_pend_r) h_r[rd_idx_r - 3'd1] <= ram_rdata;
    end
    // multiplies, registered
    if (state_r == S_MUL) begin
      mstep_r <= mstep_r + 2'd1;
      prod_r  <= mul_a * mul_b;
      case (mstep_r)
        2'd1: ycalc_r <= 32'(ysum >>> 16);
        2'd2: begin mx_r <= 24'((prod_r + 32'd128) >> 8); sx_r <= (dx != 0) && !dx[16]; end
        2'd3: begin mz_r <= 24'((prod_r + 32'd128) >> 8); sz_r <= (dz != 0) && !dz[16]; end
        default: ;
      endcase
    end
    if (state_r == S_SQ) begin
      if (ycalc_r > 32767) vy_r <= 16'h7FFF;
      else if (ycalc_r < -32768) vy_r <= 16'h8000;
      else vy_r <= ycalc_r[15:0];
      sq_v_r   <= {1'b0, l2};
      sq_res_r <= '0;
      sq_rem_r <= '0;
      sq_cnt_r <= 6'd25;
    end
    if (state_r == S_SQRT) begin
      sq_v_r   <= sq_v_nxt;
      sq_res_r <= sq_res_nxt;
      sq_rem_r <= sq_rem_nxt;
      sq_cnt_r <= sq_cnt_r - 6'd1;
      if (sq_cnt_r == 6'd1) norm_r <= sq_res_nxt;
    end
    if (div_done) begin
      case (state_r)
        S_DIVX: qx_r <= div_q;
        S_DIVY: qy_r <= div_q;
        default: qz_r <= div_q;
      endcase
    end
    if (out_load) begin
      out_data.vertex_y <= vy_r;
      out_data.normal_x <= sx_r ? 16'(-qx_r) : qx_r;
      out_data.normal_y <= qy_r[14:0];
      out_data.normal_z <= sz_r ? 16'(-qz_r) : qz_r;
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == S_IDLE) else $error("write while busy");
  a_norm_min: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIVX |-> norm_r >= 25'h10000) else $error("norm too small");
`endif

endmodule
